>>> design/hgld_pkg.sv
// shared types and defaults for the hex grid line drawer
// no dependencies; imported by every design file
package hgld_pkg;

    localparam int COORD_BITS_DEF = 5;

    typedef struct packed {
        logic capture;
        logic init;
        logic advance;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
    } t_dp_stat;

endpackage

>>> design/hgld_ctrl.sv
// sequencer for the hex grid line drawer: handshakes and datapath commands
// depends on hgld_pkg
module hgld_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    output hgld_pkg::t_dp_cmd o_cmd,
    input  hgld_pkg::t_dp_stat i_stat
);
    import hgld_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) n_state = ST_SETUP;
            end
            ST_SETUP: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!i_stall && i_stat.last) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall        = (r_state != ST_IDLE);
    assign o_valid        = (r_state == ST_EMIT);
    assign o_cmd.capture  = (r_state == ST_IDLE) && i_valid;
    assign o_cmd.init     = (r_state == ST_SETUP);
    assign o_cmd.advance  = (r_state == ST_EMIT) && !i_stall && !i_stat.last;

endmodule

>>> design/hgld_dp.sv
// datapath: hex distance, incremental cube rounding and axial output
// depends on hgld_pkg; driven by hgld_ctrl commands
module hgld_dp #(
    parameter int COORD_BITS = hgld_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  hgld_pkg::t_dp_cmd            i_cmd,
    input  logic signed [COORD_BITS-1:0] i_start_q,
    input  logic signed [COORD_BITS-1:0] i_start_r,
    input  logic signed [COORD_BITS-1:0] i_end_q,
    input  logic signed [COORD_BITS-1:0] i_end_r,
    output hgld_pkg::t_dp_stat           o_stat,
    output logic signed [COORD_BITS-1:0] o_point_q,
    output logic signed [COORD_BITS-1:0] o_point_r
);
    import hgld_pkg::*;

    localparam int NW = COORD_BITS + 1;
    localparam int DW = COORD_BITS + 2;
    localparam int EW = COORD_BITS + 4;

    logic signed [COORD_BITS-1:0] r_aq, r_ar, r_bq, r_br;
    logic        [NW-1:0]         r_n;
    logic        [NW-1:0]         r_step;
    logic signed [DW-1:0]         r_d [3];
    logic signed [DW-1:0]         r_rnd [3];
    logic signed [EW-1:0]         r_err [3];

    logic signed [DW-1:0] w_a [3];
    logic signed [DW-1:0] w_b [3];
    logic signed [DW-1:0] w_dd [3];
    logic        [DW-1:0] w_mag [3];
    logic        [DW-1:0] w_max;
    logic signed [EW:0]   w_n2;
    logic signed [EW-1:0] w_e1 [3];
    logic signed [EW:0]   w_twice [3];
    logic signed [EW-1:0] n_err [3];
    logic signed [DW-1:0] n_rnd [3];
    logic        [EW-1:0] w_abs [3];
    logic                 w_fix_q, w_fix_r;

    // cube coordinates of start and end
    always_comb begin
        w_a[0] = DW'(r_aq);
        w_a[1] = DW'(r_ar);
        w_a[2] = -w_a[0] - w_a[1];
        w_b[0] = DW'(r_bq);
        w_b[1] = DW'(r_br);
        w_b[2] = -w_b[0] - w_b[1];
        for (int k = 0; k < 3; k++) begin
            w_dd[k]  = w_b[k] - w_a[k];
            w_mag[k] = w_dd[k][DW-1] ? DW'(-w_dd[k]) : DW'(w_dd[k]);
        end
        w_max = w_mag[0];
        if (w_mag[1] > w_max) w_max = w_mag[1];
        if (w_mag[2] > w_max) w_max = w_mag[2];
    end

    // one interpolation step: error += d, then at most one carry each way
    always_comb begin
        w_n2 = (EW+1)'(r_n);
        for (int k = 0; k < 3; k++) begin
            w_e1[k]    = r_err[k] + EW'(r_d[k]);
            w_twice[k] = {w_e1[k], 1'b0};
            n_err[k]   = w_e1[k];
            n_rnd[k]   = r_rnd[k];
            if (w_twice[k] >= w_n2) begin
                n_err[k] = w_e1[k] - EW'(r_n);
                n_rnd[k] = r_rnd[k] + DW'(1);
            end else if (w_twice[k] < -w_n2) begin
                n_err[k] = w_e1[k] + EW'(r_n);
                n_rnd[k] = r_rnd[k] - DW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_aq <= i_start_q;
            r_ar <= i_start_r;
            r_bq <= i_end_q;
            r_br <= i_end_r;
        end
        if (i_cmd.init) begin
            r_n    <= w_max[NW-1:0];
            r_step <= '0;
            for (int k = 0; k < 3; k++) begin
                r_d[k]   <= w_dd[k];
                r_rnd[k] <= w_a[k];
                r_err[k] <= '0;
            end
        end else if (i_cmd.advance) begin
            r_step <= r_step + NW'(1);
            for (int k = 0; k < 3; k++) begin
                r_rnd[k] <= n_rnd[k];
                r_err[k] <= n_err[k];
            end
        end
    end

    // largest rounding error gets rebuilt from the other two
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_abs[k] = r_err[k][EW-1] ? EW'(-r_err[k]) : EW'(r_err[k]);
        end
        w_fix_q = (w_abs[0] > w_abs[1]) && (w_abs[0] > w_abs[2]);
        w_fix_r = !w_fix_q && (w_abs[1] > w_abs[2]);
    end

    logic signed [DW-1:0] w_pq, w_pr;

    assign w_pq = w_fix_q ? (-r_rnd[1] - r_rnd[2]) : r_rnd[0];
    assign w_pr = w_fix_r ? (-r_rnd[0] - r_rnd[2]) : r_rnd[1];

    assign o_point_q   = w_pq[COORD_BITS-1:0];
    assign o_point_r   = w_pr[COORD_BITS-1:0];
    assign o_stat.last = (r_step == r_n);

endmodule

>>> design/hex_grid_line_draw.sv
// top level of the hex grid line drawer
// depends on hgld_pkg, hgld_ctrl, hgld_dp
//
// usage
//   input channel: i_valid / o_stall with i_start_q, i_start_r, i_end_q,
//   i_end_r in axial coordinates; a beat is taken when i_valid is high and
//   o_stall is low. the block takes one request at a time.
//   output channel: o_valid / i_stall with o_point_q, o_point_r and
//   o_last_point; one beat per cell from start to end, N+1 beats where N is
//   the hex distance, the end cell marked by o_last_point.
//   timing: after the request beat the sequencer passes a setup state, and
//   the first cell shows in the emit state; then one cell per cycle while
//   i_stall is low; the per-cell interpolation loop sets a request's length.
//   a stall freezes the current cell on the outputs until it is taken.
//   reset (i_rst_n low, synchronous) returns the sequencer to idle with
//   o_valid low and o_stall low.
module hex_grid_line_draw #(
    parameter int COORD_BITS = hgld_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COORD_BITS-1:0] i_start_q,
    input  logic signed [COORD_BITS-1:0] i_start_r,
    input  logic signed [COORD_BITS-1:0] i_end_q,
    input  logic signed [COORD_BITS-1:0] i_end_r,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [COORD_BITS-1:0] o_point_q,
    output logic signed [COORD_BITS-1:0] o_point_r,
    output logic                         o_last_point
);
    import hgld_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    hgld_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (w_cmd),
        .i_stat  (w_stat)
    );

    hgld_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_cmd     (w_cmd),
        .i_start_q (i_start_q),
        .i_start_r (i_start_r),
        .i_end_q   (i_end_q),
        .i_end_r   (i_end_r),
        .o_stat    (w_stat),
        .o_point_q (o_point_q),
        .o_point_r (o_point_r)
    );

    assign o_last_point = w_stat.last;

endmodule

>>> tb/sv/tb_hex_grid_line_draw.sv
`timescale 1ns / 100ps
// self-checking testbench for hex_grid_line_draw: directed table, then random lines
// depends on hgld_pkg and the hex_grid_line_draw rtl; predicts each cell in-line
module tb_hex_grid_line_draw;

    localparam int CB          = hgld_pkg::COORD_BITS_DEF;
    localparam int CMAX        = (1 << CB) - 1;
    localparam int RANDOM_LINES = 300;
    localparam int PAUSE_AT    = 150;
    localparam int HOLD_AT     = 1000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 70;

    typedef logic signed [CB-1:0] t_coord;

    typedef struct packed {
        t_coord q;
        t_coord r;
        logic   last;
    } t_cell;

    // lone = 1 marks a start-equals-end row whose single cell is typed in (xq, xr)
    typedef struct packed {
        int sq, sr, eq, er, lone, xq, xr;
    } t_line_row;

    localparam int N_ROWS = 21;
    localparam t_line_row LINE_TABLE [N_ROWS] = '{
        '{  0,   0,   0,   0, 1,   0,   0},
        '{-16, -16, -16, -16, 1, -16, -16},
        '{ 15,  15,  15,  15, 1,  15,  15},
        '{-16,  15, -16,  15, 1, -16,  15},
        '{ 15, -16,  15, -16, 1,  15, -16},
        '{-16, -16,  15,  15, 0,   0,   0},
        '{ 15,  15, -16, -16, 0,   0,   0},
        '{ 15, -16, -16,  15, 0,   0,   0},
        '{-16,  15,  15, -16, 0,   0,   0},
        '{  0,   0,  15,   0, 0,   0,   0},
        '{  0,   0, -16,   0, 0,   0,   0},
        '{  0,   0,   0,  15, 0,   0,   0},
        '{  0,   0,   0, -16, 0,   0,   0},
        '{-16,   0,  15,   0, 0,   0,   0},
        '{  0,   0,   1,   1, 0,   0,   0},
        '{  0,   0,   2,  -1, 0,   0,   0},
        '{  0,   0,   1,  -2, 0,   0,   0},
        '{  3,  -5,  -4,   7, 0,   0,   0},
        '{ -7,   2,   6,  -9, 0,   0,   0},
        '{  0,   0,   1,   0, 0,   0,   0},
        '{  5,   5,  -3,  -3, 0,   0,   0}
    };

    logic   i_clk     = 1'b0;
    logic   i_rst_n   = 1'b0;
    logic   i_valid   = 1'b0;
    logic   i_stall   = 1'b0;
    t_coord i_start_q = '0;
    t_coord i_start_r = '0;
    t_coord i_end_q   = '0;
    t_coord i_end_r   = '0;
    logic   o_stall;
    logic   o_valid;
    t_coord o_point_q;
    t_coord o_point_r;
    logic   o_last_point;

    t_cell       expected_cells [$];
    t_cell       want;
    int          mismatches = 0;
    int          cells_seen = 0;
    int unsigned rx_gap     = 0;
    int unsigned rx_hold    = 0;
    bit          tx_quiet   = 1'b0;

    // predictor copy of the block state
    int     line_len  = 0;
    int     last_step = 0;
    t_coord held_sq, held_sr, held_eq, held_er;

    hex_grid_line_draw #(
        .COORD_BITS(CB)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_start_q    (i_start_q),
        .i_start_r    (i_start_r),
        .i_end_q      (i_end_q),
        .i_end_r      (i_end_r),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_point_q    (o_point_q),
        .o_point_r    (o_point_r),
        .o_last_point (o_last_point)
    );

    always #5 i_clk = ~i_clk;

    function automatic int mag(input int x);
        return (x < 0) ? -x : x;
    endfunction

    // num/den rounded half up, err is the rounding error scaled by den
    function automatic int round_half_up(input int num, input int den, output int err);
        int twice;
        int rnd;
        twice = 2 * num + den;
        rnd = twice / (2 * den);
        if ((twice % (2 * den)) != 0 && twice < 0) rnd = rnd - 1;
        err = mag(num - rnd * den);
        return rnd;
    endfunction

    function automatic void plot_line(input t_coord sq, input t_coord sr,
                                      input t_coord eq, input t_coord er);
        int    q0, r0, s0, dq, dr, ds, n;
        int    rq, rr, rs, errq, errr, errs;
        t_cell c;
        q0 = sq;
        r0 = sr;
        s0 = -q0 - r0;
        dq = int'(eq) - q0;
        dr = int'(er) - r0;
        ds = -dq - dr;
        n = mag(dq);
        if (mag(dr) > n) n = mag(dr);
        if (mag(ds) > n) n = mag(ds);
        held_sq = sq;
        held_sr = sr;
        held_eq = eq;
        held_er = er;
        line_len = n & 63;
        if (n == 0) begin
            c.q = sq;
            c.r = sr;
            c.last = 1'b1;
            expected_cells.push_back(c);
            last_step = 0;
            return;
        end
        for (int i = 0; i <= n; i++) begin
            rq = round_half_up(q0 * n + dq * i, n, errq);
            rr = round_half_up(r0 * n + dr * i, n, errr);
            rs = round_half_up(s0 * n + ds * i, n, errs);
            if (errq > errr && errq > errs) rq = -rr - rs;
            else if (errr > errs) rr = -rq - rs;
            c.q = t_coord'(rq);
            c.r = t_coord'(rr);
            c.last = (i == n);
            expected_cells.push_back(c);
        end
        last_step = n & 63;
    endfunction

    task automatic offer_line(input t_coord sq, input t_coord sr,
                              input t_coord eq, input t_coord er);
        int unsigned gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 16);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_start_q <= sq;
        i_start_r <= sr;
        i_end_q   <= eq;
        i_end_r   <= er;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // receiver: checks each cell beat and draws its own stall pattern
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_cells.size() == 0) begin
                $display("%0t unexpected cell q=%0d r=%0d last=%0b",
                         $time, o_point_q, o_point_r, o_last_point);
                mismatches++;
            end else begin
                want = expected_cells.pop_front();
                if (o_point_q !== want.q || o_point_r !== want.r ||
                    o_last_point !== want.last) begin
                    $display("%0t cell mismatch: expected q=%0d r=%0d last=%0b,",
                             $time, want.q, want.r, want.last,
                             " got q=%0d r=%0d last=%0b",
                             o_point_q, o_point_r, o_last_point);
                    mismatches++;
                end
            end
            cells_seen++;
            rx_gap = (((cells_seen / 50) % 3) == 1) ? 0 : $urandom_range(0, 16);
            if (cells_seen == HOLD_AT) rx_hold = HOLD_CYCLES;
        end
        if (rx_hold != 0) begin
            rx_hold--;
            i_stall <= 1'b1;
        end else if (rx_gap != 0) begin
            rx_gap--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    initial begin
        t_coord sq, sr, eq, er;
        t_cell  c;
        int     kind;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < N_ROWS; k++) begin
            tx_quiet = (k % 2) == 0;
            sq = t_coord'(LINE_TABLE[k].sq);
            sr = t_coord'(LINE_TABLE[k].sr);
            eq = t_coord'(LINE_TABLE[k].eq);
            er = t_coord'(LINE_TABLE[k].er);
            offer_line(sq, sr, eq, er);
            if (LINE_TABLE[k].lone != 0) begin
                c.q = t_coord'(LINE_TABLE[k].xq);
                c.r = t_coord'(LINE_TABLE[k].xr);
                c.last = 1'b1;
                expected_cells.push_back(c);
            end else begin
                plot_line(sq, sr, eq, er);
            end
        end

        for (int k = 0; k < RANDOM_LINES; k++) begin
            if (k == PAUSE_AT) begin
                i_valid <= 1'b0;
                while (expected_cells.size() != 0) @(posedge i_clk);
            end
            tx_quiet = ((k / 16) % 3) == 0;
            kind = $urandom_range(0, 9);
            sq = t_coord'($urandom_range(0, CMAX));
            sr = t_coord'($urandom_range(0, CMAX));
            if (kind == 0) begin
                eq = sq;
                er = sr;
            end else if (kind <= 3) begin
                eq = t_coord'($urandom_range(0, CMAX));
                er = t_coord'($urandom_range(0, CMAX));
            end else begin
                eq = t_coord'(int'(sq) + int'($urandom_range(0, 8)) - 4);
                er = t_coord'(int'(sr) + int'($urandom_range(0, 8)) - 4);
            end
            offer_line(sq, sr, eq, er);
            plot_line(sq, sr, eq, er);
        end
        i_valid <= 1'b0;

        while (expected_cells.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_cells.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

>>> hex_grid_line_draw.f
design/hgld_pkg.sv
design/hgld_ctrl.sv
design/hgld_dp.sv
design/hex_grid_line_draw.sv
tb/sv/tb_hex_grid_line_draw.sv
